[rtl/spsa_pkg.sv]
// Shared types and constants of the slab page slot allocator.
`timescale 1ns / 1ps

package spsa_pkg;

  localparam int SIZE_W  = 12;
  localparam int REQ_W   = 16;
  localparam int OFF_W   = 12;
  localparam int SLOT_W  = 8;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 3;
  localparam int DVS_W   = SIZE_W + 1;

  localparam int HDR_BYTES = 32;
  localparam int HDR_FIXED = 26;
  localparam int CAP_LIMIT = 254;

  localparam logic [REQ_W-1:0]  MIN_OBJ   = 16'd32;
  localparam logic [REQ_W-1:0]  MAX_OBJ   = 16'd4048;
  localparam logic [SLOT_W-1:0] CHAIN_END = 8'd255;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 8'd255;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_WRONG_CLS = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREE_EMPTY = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [REQ_W-1:0]  request_size;
    logic [OFF_W-1:0]  free_offset;
  } spsa_req_t;

  typedef struct packed {
    logic [OFF_W-1:0]  obj_offset;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  live_count;
    logic              page_released;
  } spsa_res_t;

endpackage

[rtl/slab_page_slot_allocator.sv]
// Top level of the slab page slot allocator: sequencer, page state and result register.
`timescale 1ns / 1ps

// One request is taken when start is high and busy is low; busy then stays high
// until the cycle in which its single result is shown on res_o under res_valid_o,
// and a new request may be taken in that same cycle. The receiver cannot stall: the
// result must be taken in that cycle. An allocate with no page present builds the
// page: a division of (PAGE_BYTES-32) by (slot size + 1) in the shared
// one-bit-per-cycle divider (max(clog2(PAGE_BYTES-31),12) steps) and then one
// free-list entry written per cycle through the table's single write port (capacity
// entries, up to MAX_SLOTS). A free divides the slot offset, less the offset of the
// first slot, by the page's slot size in the same divider. The user must see that
// slot_size is written only while idle; the block itself does not enforce it.
module slab_page_slot_allocator #(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_SLOTS  = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  spsa_pkg::spsa_req_t   req_i,
  input  logic                  cfg_we_i,
  input  logic [11:0]           cfg_wdata_i,
  output logic                  res_valid_o,
  output spsa_pkg::spsa_res_t   res_o
);

  import spsa_pkg::*;

  localparam int SPAN   = PAGE_BYTES - HDR_BYTES;
  localparam int SPAN_W = $clog2(SPAN + 1);
  localparam int DVD_W  = (SPAN_W > OFF_W) ? SPAN_W : OFF_W;
  localparam int IDX_W  = $clog2(MAX_SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CAPDIV = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_ALLOC  = 3'd4;
  localparam logic [2:0] S_ALLOC2 = 3'd5;
  localparam logic [2:0] S_IDXDIV = 3'd6;

  logic [2:0]        state_q, state_d;
  spsa_req_t         req_q, req_d;
  logic [SIZE_W-1:0] slot_size_q;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              present_q, present_d;
  logic [SLOT_W-1:0] cap_q, cap_d;
  logic [OFF_W-1:0]  first_q, first_d;
  logic [SIZE_W-1:0] pss_q, pss_d;
  logic [SLOT_W-1:0] fill_q, fill_d;
  logic [OFF_W-1:0]  prod_q, prod_d;
  logic              res_valid_q, res_valid_d;
  spsa_res_t         res_q, res_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] ram_rdata;

  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DVD_W-1:0]  div_quot;

  logic [REQ_W-1:0]  size_clamped;
  logic [DVS_W-1:0]  size_rounded;
  logic [SLOT_W-1:0] cap_calc;
  logic [19:0]       prod_full;
  logic [OFF_W-1:0]  free_span;

  assign size_clamped = (req_q.request_size < MIN_OBJ) ? MIN_OBJ : req_q.request_size;
  assign size_rounded = ({1'b0, size_clamped[SIZE_W-1:0]} + DVS_W'(15)) & ~DVS_W'(15);
  assign prod_full    = 20'(head_q) * 20'(pss_q);
  assign free_span    = req_q.free_offset - first_q;

  always_comb begin
    if (div_quot > DVD_W'(MAX_SLOTS)) begin
      cap_calc = SLOT_W'(MAX_SLOTS);
    end else if (div_quot > DVD_W'(CAP_LIMIT)) begin
      cap_calc = SLOT_W'(CAP_LIMIT);
    end else begin
      cap_calc = div_quot[SLOT_W-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    head_d       = head_q;
    count_d      = count_q;
    present_d    = present_q;
    cap_d        = cap_q;
    first_d      = first_q;
    pss_d        = pss_q;
    fill_d       = fill_q;
    prod_d       = prod_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = fill_q[IDX_W-1:0];
    ram_wdata    = fill_q + SLOT_W'(1);
    div_start    = 1'b0;
    div_dividend = DVD_W'(SPAN);
    div_divisor  = {1'b0, slot_size_q} + DVS_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_d = '{obj_offset: '0, status: ST_OK, live_count: count_q, page_released: 1'b0};
        if (req_q.req_type == REQ_ALLOC) begin
          if (req_q.request_size > MAX_OBJ) begin
            res_d.status = ST_TOO_LARGE;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else if (size_rounded != {1'b0, slot_size_q}) begin
            res_d.status = ST_WRONG_CLS;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else if (!present_q) begin
            div_start = 1'b1;
            state_d   = S_CAPDIV;
          end else begin
            state_d = S_ALLOC;
          end
        end else begin
          if (!present_q || count_q == '0) begin
            res_d.status = ST_FREE_EMPTY;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else if (req_q.free_offset < first_q || pss_q == '0) begin
            res_d.status = ST_WRONG_CLS;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(free_span);
            div_divisor  = {1'b0, pss_q};
            state_d      = S_IDXDIV;
          end
        end
      end
      S_CAPDIV: begin
        if (div_done) begin
          if (cap_calc == '0) begin
            res_d.status = ST_NO_SLOT;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cap_d     = cap_calc;
            first_d   = (OFF_W'(cap_calc) + OFF_W'(HDR_FIXED + 15)) & ~OFF_W'(15);
            pss_d     = slot_size_q;
            head_d    = '0;
            count_d   = '0;
            present_d = 1'b1;
            fill_d    = '0;
            state_d   = S_FILL;
          end
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        fill_d = fill_q + SLOT_W'(1);
        if (fill_q == cap_q - SLOT_W'(1)) begin
          ram_wdata = CHAIN_END;
          state_d   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (head_q == CHAIN_END || head_q >= cap_q) begin
          res_d.status = ST_NO_SLOT;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          prod_d  = prod_full[OFF_W-1:0];
          state_d = S_ALLOC2;
        end
      end
      S_ALLOC2: begin
        head_d = ram_rdata;
        if (count_q != CNT_MAX) begin
          count_d = count_q + CNT_W'(1);
        end
        res_d.obj_offset = first_q + prod_q;
        res_d.status     = ST_OK;
        res_d.live_count = count_d;
        res_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      S_IDXDIV: begin
        if (div_done) begin
          if (div_quot >= DVD_W'(cap_q)) begin
            res_d.status = ST_WRONG_CLS;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = div_quot[IDX_W-1:0];
            ram_wdata = head_q;
            head_d    = div_quot[SLOT_W-1:0];
            count_d   = count_q - CNT_W'(1);
            if (count_d == '0) begin
              present_d           = 1'b0;
              res_d.page_released = 1'b1;
            end
            res_d.status     = ST_OK;
            res_d.live_count = count_d;
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_size_q <= SIZE_W'(32);
      head_q      <= '0;
      count_q     <= '0;
      present_q   <= 1'b0;
      cap_q       <= '0;
      first_q     <= '0;
      pss_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      present_q   <= present_d;
      cap_q       <= cap_d;
      first_q     <= first_d;
      pss_q       <= pss_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        slot_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    fill_q <= fill_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  spsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_next_free (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  spsa_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/spsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spsa_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module spsa_div #(
  parameter int DVD_W = 12,
  parameter int DVS_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = CW'(DVD_W);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[DVS_W]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
